// ----- hw/rtl/bbc_pkg.sv -----
// Shared types and constants for the clipped box blur.
package bbc_pkg;

	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int unsigned WIDTH_W = 11;
	localparam int unsigned HEIGHT_W = 13;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

	// Configuration register indexes
	localparam logic [0:0] CFG_WIDTH = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       flush;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} pix_out_t;

endpackage

// ----- hw/rtl/box_blur_11x11_clipped.sv -----
// Streaming clipped box blur over RGB frames, top level.
//
// Pixels enter in raster order; each result is the per-channel truncated mean of the
// (2*RADIUS+1)-square window around an output pixel, clipped to the frame. Results come
// out in raster order once their whole window has arrived; flush beats drain the tail.
// The block works on one beat at a time and takes no new beat until the last is done; a
// beat that yields a result waits for one line-store read per window pixel and a
// bit-serial divider. Config writes restart the frame.
module box_blur_11x11_clipped
	import bbc_pkg::*;
#(
	parameter int unsigned RADIUS = 5,
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  pix_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output pix_out_t    out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int unsigned RING = 2 * RADIUS + 2;
	localparam int unsigned SIDE = 2 * RADIUS + 1;
	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = 12;
	localparam int unsigned MW = $clog2(RING);
	localparam int unsigned AW = $clog2(RING * MAX_WIDTH);
	localparam int unsigned NW = $clog2(SIDE * SIDE + 1);
	localparam int unsigned SW = $clog2(SIDE * SIDE * 255 + 1);
	localparam int unsigned DW = $clog2(SW + 1);
	localparam int unsigned SPW = $clog2(SIDE + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_READ, ST_DRAIN, ST_DIV, ST_OUT} state_t;

	state_t state_q;
	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [MW-1:0] row_mod_q;
	logic [CW-1:0] kx_q;
	logic [RW-1:0] ky_q;
	logic [MW-1:0] ky_mod_q;
	logic fc_q;
	logic [RW-1:0] rr_q, r1_q;
	logic [MW-1:0] rmod_q;
	logic [CW-1:0] cc_q, c0_q, c1_q;
	logic [NW-1:0] n_q;
	logic [SW-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [NW:0] rem_r_q, rem_g_q, rem_b_q;
	logic [DW-1:0] step_q;
	logic rd_valid_s1;
	logic [23:0] rd_data_s1;
	logic out_valid_q;
	pix_out_t out_q;

	logic [23:0] mem [RING * MAX_WIDTH];

	// Clamp the size registers
	logic [WW-1:0] w_used;
	logic [HEIGHT_W-1:0] h_used;
	always_comb begin
		if (width_q == '0) w_used = WW'(1);
		else if (WW'(width_q) > WW'(MAX_WIDTH) || width_q > WIDTH_W'(MAX_WIDTH))
			w_used = WW'(MAX_WIDTH);
		else w_used = WW'(width_q);
		if (height_q == '0) h_used = HEIGHT_W'(1);
		else if (height_q > HEIGHT_W'(HEIGHT_LIMIT)) h_used = HEIGHT_W'(HEIGHT_LIMIT);
		else h_used = height_q;
	end

	// Window bounds of the next output pixel
	logic [RW-1:0] r0_c, r1_c;
	logic [CW-1:0] c0_c, c1_c;
	logic [RW:0] ky_hi;
	logic [CW:0] kx_hi;
	logic [MW-1:0] r0_mod_c;
	logic win_ready;
	logic [SPW-1:0] rows_span, cols_span;
	always_comb begin
		r0_c = (ky_q >= RW'(RADIUS)) ? ky_q - RW'(RADIUS) : '0;
		c0_c = (kx_q >= CW'(RADIUS)) ? kx_q - CW'(RADIUS) : '0;
		ky_hi = {1'b0, ky_q} + (RW+1)'(RADIUS);
		kx_hi = {1'b0, kx_q} + (CW+1)'(RADIUS);
		r1_c = (ky_hi > (RW+1)'(h_used - 1'b1)) ? RW'(h_used - 1'b1) : RW'(ky_hi);
		c1_c = (kx_hi > (CW+1)'(w_used - 1'b1)) ? CW'(w_used - 1'b1) : CW'(kx_hi);
		if (ky_q < RW'(RADIUS)) r0_mod_c = '0;
		else if (ky_mod_q >= MW'(RADIUS)) r0_mod_c = ky_mod_q - MW'(RADIUS);
		else r0_mod_c = MW'(ky_mod_q + MW'(RING - RADIUS));
		win_ready = fc_q || (r1_c < row_q) || (r1_c == row_q && c1_c < col_q);
		rows_span = SPW'(r1_c - r0_c + 1'b1);
		cols_span = SPW'(c1_c - c0_c + 1'b1);
	end

	logic last_c;
	assign last_c = (ky_q == RW'(h_used - 1'b1)) && (WW'(kx_q) == w_used - 1'b1);

	// Line store: write on pixel beats, registered read during the window sweep
	logic wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	assign wr_en = (state_q == ST_IDLE) && in_valid && !in_data.flush;
	assign wr_addr = AW'(row_mod_q) * AW'(MAX_WIDTH) + AW'(col_q);
	assign rd_addr = AW'(rmod_q) * AW'(MAX_WIDTH) + AW'(cc_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= {in_data.red_in, in_data.green_in, in_data.blue_in};
		if (state_q == ST_READ) rd_data_s1 <= mem[rd_addr];
	end

	// Divider step per channel
	logic [NW:0] tr_r, tr_g, tr_b;
	assign tr_r = {rem_r_q[NW-1:0], sum_r_q[SW-1]};
	assign tr_g = {rem_g_q[NW-1:0], sum_g_q[SW-1]};
	assign tr_b = {rem_b_q[NW-1:0], sum_b_q[SW-1]};

	// Sequencer, accumulators and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q <= '0;
			row_q <= '0;
			row_mod_q <= '0;
			kx_q <= '0;
			ky_q <= '0;
			ky_mod_q <= '0;
			fc_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_OUT) out_valid_q <= 1'b0;
			rd_valid_s1 <= (state_q == ST_READ);
			if (rd_valid_s1) begin
				sum_r_q <= sum_r_q + SW'(rd_data_s1[23:16]);
				sum_g_q <= sum_g_q + SW'(rd_data_s1[15:8]);
				sum_b_q <= sum_b_q + SW'(rd_data_s1[7:0]);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						if (cfg_index == CFG_WIDTH) width_q <= cfg_data[WIDTH_W-1:0];
						else height_q <= cfg_data;
						col_q <= '0;
						row_q <= '0;
						row_mod_q <= '0;
						kx_q <= '0;
						ky_q <= '0;
						ky_mod_q <= '0;
						fc_q <= 1'b0;
					end else if (in_valid) begin
						state_q <= ST_CHECK;
						if (!in_data.flush) begin
							// drop what the old frame still owed
							if (fc_q) begin
								kx_q <= '0;
								ky_q <= '0;
								ky_mod_q <= '0;
								fc_q <= 1'b0;
							end
							if (WW'(col_q) + 1'b1 >= w_used) begin
								col_q <= '0;
								row_mod_q <= (row_mod_q == MW'(RING - 1)) ? '0 : row_mod_q + 1'b1;
								if ((HEIGHT_W)'(row_q) + 1'b1 >= h_used) begin
									row_q <= '0;
									row_mod_q <= '0;
									fc_q <= 1'b1;
								end else begin
									row_q <= row_q + 1'b1;
								end
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				ST_CHECK: begin
					if (win_ready) begin
						state_q <= ST_READ;
						rr_q <= r0_c;
						r1_q <= r1_c;
						rmod_q <= r0_mod_c;
						cc_q <= c0_c;
						c0_q <= c0_c;
						c1_q <= c1_c;
						n_q <= NW'(rows_span) * NW'(cols_span);
						sum_r_q <= '0;
						sum_g_q <= '0;
						sum_b_q <= '0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					// sweep the window, one pixel per cycle
					if (cc_q == c1_q) begin
						cc_q <= c0_q;
						if (rr_q == r1_q) state_q <= ST_DRAIN;
						rr_q <= rr_q + 1'b1;
						rmod_q <= (rmod_q == MW'(RING - 1)) ? '0 : rmod_q + 1'b1;
					end else begin
						cc_q <= cc_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DIV;
					step_q <= '0;
					rem_r_q <= '0;
					rem_g_q <= '0;
					rem_b_q <= '0;
				end
				ST_DIV: begin
					// restoring divide, quotient shifts into the sum registers
					if (tr_r >= (NW+1)'(n_q)) begin
						rem_r_q <= tr_r - (NW+1)'(n_q);
						sum_r_q <= {sum_r_q[SW-2:0], 1'b1};
					end else begin
						rem_r_q <= tr_r;
						sum_r_q <= {sum_r_q[SW-2:0], 1'b0};
					end
					if (tr_g >= (NW+1)'(n_q)) begin
						rem_g_q <= tr_g - (NW+1)'(n_q);
						sum_g_q <= {sum_g_q[SW-2:0], 1'b1};
					end else begin
						rem_g_q <= tr_g;
						sum_g_q <= {sum_g_q[SW-2:0], 1'b0};
					end
					if (tr_b >= (NW+1)'(n_q)) begin
						rem_b_q <= tr_b - (NW+1)'(n_q);
						sum_b_q <= {sum_b_q[SW-2:0], 1'b1};
					end else begin
						rem_b_q <= tr_b;
						sum_b_q <= {sum_b_q[SW-2:0], 1'b0};
					end
					step_q <= step_q + 1'b1;
					if (step_q == DW'(SW - 1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					// hand the beat over once the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_q.red_out <= sum_r_q[7:0];
						out_q.green_out <= sum_g_q[7:0];
						out_q.blue_out <= sum_b_q[7:0];
						out_q.frame_last <= last_c;
						state_q <= ST_IDLE;
						if (last_c) begin
							kx_q <= '0;
							ky_q <= '0;
							ky_mod_q <= '0;
							fc_q <= 1'b0;
						end else if (WW'(kx_q) + 1'b1 >= w_used) begin
							kx_q <= '0;
							ky_q <= ky_q + 1'b1;
							ky_mod_q <= (ky_mod_q == MW'(RING - 1)) ? '0 : ky_mod_q + 1'b1;
						end else begin
							kx_q <= kx_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != ST_IDLE) || cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
